[hw/rtl/u8d_pkg.sv]
// Shared types for the UTF-8 to UTF-32 decoder.
// Holds the input, result and internal command item layouts; no dependencies.
`default_nettype none

package u8d_pkg;

    // Width of a sequence length index (length minus one, 0 to 5).
    localparam int unsigned LEN_IDX_W = 3;

    // One input item: a raw stream byte and the end-of-string flag.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [31:0] code_point;
        logic        truncated;
        logic        end_of_string;
    } t_out_item;

    // A classified byte passed from the front to the back.
    typedef struct packed {
        logic [7:0]           byte_value;
        logic                 is_lead;
        logic [LEN_IDX_W-1:0] len_idx;
        logic                 complete;
        logic                 last_byte;
    } t_cmd;

endpackage

`default_nettype wire

[hw/rtl/u8d_front.sv]
// Front end of the decoder: accepts bytes and classifies them.
// Tracks the open sequence length and bytes left; uses u8d_pkg.
`default_nettype none

module u8d_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire u8d_pkg::t_in_item i_item,
    output u8d_pkg::t_cmd        o_cmd
);
    import u8d_pkg::*;

    localparam logic [7:0] LEAD_2 = 8'd192;
    localparam logic [7:0] LEAD_3 = 8'd224;
    localparam logic [7:0] LEAD_4 = 8'd240;
    localparam logic [7:0] LEAD_5 = 8'd248;
    localparam logic [7:0] LEAD_6 = 8'd252;

    logic [2:0]           r_bytes_left;
    logic [2:0]           n_bytes_left;
    logic [LEN_IDX_W-1:0] r_len_idx;
    logic [LEN_IDX_W-1:0] n_len_idx;
    logic [LEN_IDX_W-1:0] lead_idx;
    logic                 is_lead;

    // Sequence length from the lead byte, as length minus one.
    always_comb begin
        if (i_item.byte_value < LEAD_2) begin
            lead_idx = 3'd0;
        end else if (i_item.byte_value < LEAD_3) begin
            lead_idx = 3'd1;
        end else if (i_item.byte_value < LEAD_4) begin
            lead_idx = 3'd2;
        end else if (i_item.byte_value < LEAD_5) begin
            lead_idx = 3'd3;
        end else if (i_item.byte_value < LEAD_6) begin
            lead_idx = 3'd4;
        end else begin
            lead_idx = 3'd5;
        end
    end

    // Classify the byte and work out the sequence state after it.
    always_comb begin
        is_lead = (r_bytes_left == 3'd0);
        if (is_lead) begin
            n_len_idx    = lead_idx;
            n_bytes_left = lead_idx;
        end else begin
            n_len_idx    = r_len_idx;
            n_bytes_left = r_bytes_left - 3'd1;
        end
        o_cmd.byte_value = i_item.byte_value;
        o_cmd.is_lead    = is_lead;
        o_cmd.len_idx    = n_len_idx;
        o_cmd.complete   = (n_bytes_left == 3'd0);
        o_cmd.last_byte  = i_item.last_byte;
    end

    // The end of a string closes any open sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 3'd0;
            r_len_idx    <= '0;
        end else if (i_accept) begin
            r_len_idx    <= n_len_idx;
            r_bytes_left <= i_item.last_byte ? 3'd0 : n_bytes_left;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/u8d_queue.sv]
// Short command queue between the decoder front and back.
// A circular buffer of classified bytes; uses u8d_pkg.
`default_nettype none

module u8d_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire u8d_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_rd,
    output u8d_pkg::t_cmd      o_cmd,
    output logic               o_empty
);
    import u8d_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/u8d_back.sv]
// Back end of the decoder: accumulates bytes and forms code points.
// Holds the invalid character register and the result register; uses u8d_pkg.
`default_nettype none

module u8d_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_wr,
    input  wire logic [31:0]     i_cfg_data,
    input  wire u8d_pkg::t_cmd   i_cmd,
    input  wire logic            i_cmd_empty,
    output logic                 o_cmd_rd,
    output u8d_pkg::t_out_item   o_item,
    output logic                 o_valid,
    input  wire logic            i_pop
);
    import u8d_pkg::*;

    localparam logic [31:0] OFFSETS [6] = '{
        32'h0000_0000, 32'h0000_3080, 32'h000E_2080,
        32'h03C8_2080, 32'hFA08_2080, 32'h8208_2080
    };

    logic [31:0] r_invalid_char;
    logic [31:0] r_acc;
    logic [31:0] n_acc;
    logic [31:0] offset;
    logic        emits;
    t_out_item   r_out;
    logic        r_out_valid;
    t_out_item   n_out;

    assign o_item  = r_out;
    assign o_valid = r_out_valid;

    // Take a command whenever the result register is free or being drained.
    assign o_cmd_rd = !i_cmd_empty && (!r_out_valid || i_pop);

    // Fold the byte in and form the result.
    always_comb begin
        if (i_cmd.is_lead) begin
            n_acc = {24'd0, i_cmd.byte_value};
        end else begin
            n_acc = {r_acc[25:0], 6'd0} + {24'd0, i_cmd.byte_value};
        end
        case (i_cmd.len_idx)
            3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5: offset = OFFSETS[i_cmd.len_idx];
            default: offset = OFFSETS[0];
        endcase
        emits = i_cmd.complete || i_cmd.last_byte;
        if (i_cmd.complete) begin
            n_out.code_point = n_acc - offset;
            n_out.truncated  = 1'b0;
        end else begin
            n_out.code_point = r_invalid_char;
            n_out.truncated  = 1'b1;
        end
        n_out.end_of_string = i_cmd.last_byte;
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invalid_char <= 32'd0;
        end else if (i_cfg_wr) begin
            r_invalid_char <= i_cfg_data;
        end
    end

    // Accumulator; a lead byte always overwrites it, so closing needs no clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 32'd0;
        end else if (o_cmd_rd) begin
            r_acc <= n_acc;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd_rd && emits) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_rd && emits) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/utf8_to_utf32_decoder.sv]
// Top level of the UTF-8 to UTF-32 decoder.
// Connects u8d_front, u8d_queue and u8d_back; uses u8d_pkg.
//
// The decoder takes one UTF-8 byte per cycle through a queue-style push/full
// port and returns code points through an empty/pop port. A byte is accepted
// every cycle while full is low; a completed or truncated sequence is registered
// onto the result port when the back end takes its last byte, and the
// result register drains at one item per cycle when pop is held. The front
// classifies each byte in the cycle it is accepted, and a QUEUE_DEPTH-entry
// command queue lets the front keep accepting while the result side stalls.
// The invalid character register is written through the cfg channel, which
// is always ready.
`default_nettype none

module utf8_to_utf32_decoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire u8d_pkg::t_in_item  i_item,
    output logic                    empty,
    input  wire logic               pop,
    output u8d_pkg::t_out_item      o_item,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [31:0]        i_cfg_data
);
    import u8d_pkg::*;

    t_cmd front_cmd;
    t_cmd back_cmd;
    logic accept;
    logic q_empty;
    logic q_rd;
    logic out_valid;

    assign accept      = push && !full;
    assign o_cfg_ready = 1'b1;
    assign empty       = !out_valid;

    // Classification of incoming bytes.
    u8d_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_cmd    (front_cmd)
    );

    // Decoupling queue.
    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_cmd   (back_cmd),
        .o_empty (q_empty)
    );

    // Accumulation and result delivery.
    u8d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (back_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_rd    (q_rd),
        .o_item      (o_item),
        .o_valid     (out_valid),
        .i_pop       (pop)
    );

endmodule

`default_nettype wire
